@@ hw/rtl/sap_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_pkg
// Shared constants and helpers for the shelf atlas packer.
// ----------------------------------------------------------------------------
package sap_pkg;

    localparam int MIN_SIDE_DEF = 128;
    localparam int MAX_SIDE_DEF = 2048;

    localparam int GLYPH_W_W  = 11;
    localparam int LH_W       = 8;
    localparam int PAD_W      = 4;
    localparam int SIZE_W     = 12;
    localparam int ORIGIN_W   = 11;
    localparam int S_DATA_W   = 16;
    localparam int S_USER_W   = 3;
    localparam int M_DATA_W   = 40;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LH_W-1:0]  LINE_HEIGHT_RST = 8'd16;
    localparam logic [PAD_W-1:0] PADDING_RST     = 4'd2;

    // register select, taken from paddr[2]
    localparam logic REG_LINE_HEIGHT = 1'b0;
    localparam logic REG_PADDING     = 1'b1;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_PLACE   = 1'b1;

    // number of trial sides MIN_SIDE << i that do not exceed MAX_SIDE
    function automatic int trial_count(int lo, int hi);
        int n;
        n = 0;
        for (int i = 0; i < 16; i++)
        begin
            if ((lo << i) <= hi)
                n++;
        end
        return n;
    endfunction

    // origin width: holds every side and the widest glyph step after a wrap
    function automatic int pos_width(int hi);
        int lg;
        lg = $clog2(hi) + 1;
        return (lg > 12) ? lg : 12;
    endfunction

endpackage

@@ hw/rtl/sap_shelf_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_shelf_step
// One shelf step: wrap to a new shelf if the glyph reaches the right edge,
// give the glyph origin and the advanced column, flag a shelf past the edge.
// ----------------------------------------------------------------------------
module sap_shelf_step #(
    parameter int POS_W = 12
) (
    input  logic [POS_W-1:0]              col,
    input  logic [POS_W-1:0]              row,
    input  logic [sap_pkg::GLYPH_W_W-1:0] w,
    input  logic [sap_pkg::PAD_W-1:0]     pad,
    input  logic [sap_pkg::LH_W-1:0]      lh,
    input  logic [POS_W-1:0]              side,
    output logic [POS_W-1:0]              ox,
    output logic [POS_W-1:0]              oy,
    output logic [POS_W-1:0]              col_next,
    output logic                          over
);

    localparam int SW = POS_W + 1;

    logic [SW-1:0]    sum;
    logic [SW-1:0]    rsum;
    logic [SW-1:0]    csum;
    logic [SW-1:0]    osum;
    logic [POS_W-1:0] row_wrap;
    logic             wrap;

    assign sum  = {1'b0, col} + SW'(w) + SW'(pad);
    assign wrap = sum >= {1'b0, side};

    // saturate the shelf origin; any row past the largest side acts the same
    assign rsum     = {1'b0, row} + SW'(lh) + SW'(pad);
    assign row_wrap = rsum[POS_W] ? {POS_W{1'b1}} : rsum[POS_W-1:0];

    assign ox = wrap ? POS_W'(pad) : col;
    assign oy = wrap ? row_wrap : row;

    assign csum     = {1'b0, ox} + SW'(w) + SW'(pad);
    assign col_next = csum[POS_W-1:0];

    assign osum = {1'b0, oy} + SW'(pad);
    assign over = osum >= {1'b0, side};

endmodule

@@ hw/rtl/shelf_atlas_packer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shelf_atlas_packer
// Pipeline: an accepted input beat sits in the input register, and its result
// beat in the result register. Throughput: one beat per cycle while m_tready
// holds; each register holds a beat, and all trial packers step side by side.
// Reset: line_height 16, padding 2, all trials fitting with origins at 2,
// no size chosen, place origins at 2; both stages empty.
// ----------------------------------------------------------------------------
module shelf_atlas_packer #(
    parameter int MIN_SIDE = sap_pkg::MIN_SIDE_DEF,
    parameter int MAX_SIDE = sap_pkg::MAX_SIDE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sap_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sap_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sap_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sap_pkg::S_DATA_W-1:0]   s_tdata,   // glyph_width[10:0], zeros
    input  logic [sap_pkg::S_USER_W-1:0]   s_tuser,   // op[0], glyph_ok[1], first[2]
    input  logic                           s_tlast,   // last
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sap_pkg::M_DATA_W-1:0]   m_tdata    // atlas_size[11:0], fits[12],
                                                      // origin_x[23:13],
                                                      // origin_y[34:24],
                                                      // placed[35], zeros
);

    localparam int NUM_TRIALS = sap_pkg::trial_count(MIN_SIDE, MAX_SIDE);
    localparam int POS_W      = sap_pkg::pos_width(MAX_SIDE);
    localparam int GW         = sap_pkg::GLYPH_W_W;
    localparam int OW         = sap_pkg::ORIGIN_W;

    // ---------------- configuration ----------------
    logic [sap_pkg::LH_W-1:0]  line_height_reg;
    logic [sap_pkg::PAD_W-1:0] padding_reg;
    logic                      cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_height_reg <= sap_pkg::LINE_HEIGHT_RST;
            padding_reg     <= sap_pkg::PADDING_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                sap_pkg::REG_LINE_HEIGHT: line_height_reg <= pwdata[sap_pkg::LH_W-1:0];
                sap_pkg::REG_PADDING:     padding_reg     <= pwdata[sap_pkg::PAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            sap_pkg::REG_LINE_HEIGHT: prdata = sap_pkg::APB_DATA_W'(line_height_reg);
            sap_pkg::REG_PADDING:     prdata = sap_pkg::APB_DATA_W'(padding_reg);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic          in_valid_reg;
    logic          in_op_reg;
    logic [GW-1:0] in_w_reg;
    logic          in_ok_reg;
    logic          in_first_reg;
    logic          in_last_reg;
    logic          m_tvalid_reg;
    logic [sap_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic          out_free;
    logic          proc;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_free;
    assign proc     = in_valid_reg && out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_free)
                m_tvalid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg    <= s_tuser[0];
            in_w_reg     <= s_tdata[GW-1:0];
            in_ok_reg    <= s_tuser[1];
            in_first_reg <= s_tuser[2];
            in_last_reg  <= s_tlast;
        end
    end

    // ---------------- measure: trial packers ----------------
    logic [POS_W-1:0]      pad_pos;
    logic [GW-1:0]         meas_w;
    logic [POS_W-1:0]      trial_col_reg  [NUM_TRIALS];
    logic [POS_W-1:0]      trial_row_reg  [NUM_TRIALS];
    logic [NUM_TRIALS-1:0] trial_fits_reg;
    logic [POS_W-1:0]      trial_col_next [NUM_TRIALS];
    logic [POS_W-1:0]      trial_row_next [NUM_TRIALS];
    logic [NUM_TRIALS-1:0] trial_fits_next;

    assign pad_pos = POS_W'(padding_reg);
    assign meas_w  = in_ok_reg ? in_w_reg : '0;

    for (genvar i = 0; i < NUM_TRIALS; i++)
    begin : g_trial
        localparam logic [POS_W-1:0] SIDE = POS_W'(MIN_SIDE << i);

        logic [POS_W-1:0] col_cur;
        logic [POS_W-1:0] row_cur;
        logic             fits_cur;
        logic [POS_W-1:0] step_row;
        logic [POS_W-1:0] step_col;
        logic             step_over;

        // a first beat restarts the trial before stepping
        assign col_cur  = in_first_reg ? pad_pos : trial_col_reg[i];
        assign row_cur  = in_first_reg ? pad_pos : trial_row_reg[i];
        assign fits_cur = in_first_reg || trial_fits_reg[i];

        sap_shelf_step #(
            .POS_W (POS_W)
        ) u_step (
            .col      (col_cur),
            .row      (row_cur),
            .w        (meas_w),
            .pad      (padding_reg),
            .lh       (line_height_reg),
            .side     (SIDE),
            .ox       (),
            .oy       (step_row),
            .col_next (step_col),
            .over     (step_over)
        );

        // a failed trial holds until the next first beat
        assign trial_col_next[i]  = fits_cur ? step_col : col_cur;
        assign trial_row_next[i]  = fits_cur ? step_row : row_cur;
        assign trial_fits_next[i] = fits_cur && !step_over;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_TRIALS; k++)
            begin
                trial_col_reg[k] <= POS_W'(sap_pkg::PADDING_RST);
                trial_row_reg[k] <= POS_W'(sap_pkg::PADDING_RST);
            end
            trial_fits_reg <= '1;
        end
        else if (proc && in_op_reg == sap_pkg::OP_MEASURE)
        begin
            for (int k = 0; k < NUM_TRIALS; k++)
            begin
                trial_col_reg[k] <= trial_col_next[k];
                trial_row_reg[k] <= trial_row_next[k];
            end
            trial_fits_reg <= trial_fits_next;
        end
    end

    // smallest side still fitting
    logic [POS_W-1:0] meas_size;

    always_comb
    begin
        meas_size = '0;
        for (int k = NUM_TRIALS - 1; k >= 0; k--)
        begin
            if (trial_fits_next[k])
                meas_size = POS_W'(MIN_SIDE << k);
        end
    end

    // ---------------- place pass ----------------
    logic [POS_W-1:0] chosen_size_reg;
    logic [POS_W-1:0] chosen_size_next;
    logic [POS_W-1:0] place_col_reg;
    logic [POS_W-1:0] place_row_reg;
    logic [POS_W-1:0] place_col_next;
    logic [POS_W-1:0] place_row_next;
    logic [POS_W-1:0] pcol_cur;
    logic [POS_W-1:0] prow_cur;
    logic [POS_W-1:0] p_ox;
    logic [POS_W-1:0] p_oy;
    logic [POS_W-1:0] p_col;
    logic             p_over;
    logic             place_go;
    logic             placed;

    assign pcol_cur = in_first_reg ? pad_pos : place_col_reg;
    assign prow_cur = in_first_reg ? pad_pos : place_row_reg;
    assign place_go = in_ok_reg && (chosen_size_reg != '0);

    sap_shelf_step #(
        .POS_W (POS_W)
    ) u_place_step (
        .col      (pcol_cur),
        .row      (prow_cur),
        .w        (in_w_reg),
        .pad      (padding_reg),
        .lh       (line_height_reg),
        .side     (chosen_size_reg),
        .ox       (p_ox),
        .oy       (p_oy),
        .col_next (p_col),
        .over     (p_over)
    );

    // an overflowing shelf still advances the origins
    assign place_col_next   = place_go ? p_col : pcol_cur;
    assign place_row_next   = place_go ? p_oy : prow_cur;
    assign placed           = place_go && !p_over;
    assign chosen_size_next = in_last_reg ? meas_size : chosen_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chosen_size_reg <= '0;
            place_col_reg   <= POS_W'(sap_pkg::PADDING_RST);
            place_row_reg   <= POS_W'(sap_pkg::PADDING_RST);
        end
        else if (proc)
        begin
            if (in_op_reg == sap_pkg::OP_MEASURE)
                chosen_size_reg <= chosen_size_next;
            else
            begin
                place_col_reg <= place_col_next;
                place_row_reg <= place_row_next;
            end
        end
    end

    // ---------------- result beat ----------------
    logic [sap_pkg::SIZE_W-1:0] res_size;
    logic                       res_fits;
    logic [OW-1:0]              res_ox;
    logic [OW-1:0]              res_oy;
    logic                       res_placed;

    always_comb
    begin
        res_size   = '0;
        res_fits   = 1'b0;
        res_ox     = '0;
        res_oy     = '0;
        res_placed = 1'b0;
        case (in_op_reg)
            sap_pkg::OP_MEASURE:
            begin
                res_size = meas_size[sap_pkg::SIZE_W-1:0];
                res_fits = |trial_fits_next;
            end
            sap_pkg::OP_PLACE:
            begin
                res_size   = chosen_size_reg[sap_pkg::SIZE_W-1:0];
                res_fits   = chosen_size_reg != '0;
                res_placed = placed;
                if (placed)
                begin
                    // clamp wide origins to the port range
                    res_ox = (|p_ox[POS_W-1:OW]) ? {OW{1'b1}} : p_ox[OW-1:0];
                    res_oy = (|p_oy[POS_W-1:OW]) ? {OW{1'b1}} : p_oy[OW-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (proc)
            m_tdata_reg <= {4'b0, res_placed, res_oy, res_ox, res_fits, res_size};
    end

    // ---------------- assertions ----------------
    a_placed_fits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && m_tdata_reg[35] |-> m_tdata_reg[12])
        else $error("placed beat without a fitting size");

    a_unplaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && !m_tdata_reg[35] |-> m_tdata_reg[34:13] == '0)
        else $error("origins set on a beat that was not placed");

    a_chosen_latch: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_op_reg == sap_pkg::OP_MEASURE && in_last_reg
        |=> chosen_size_reg[sap_pkg::SIZE_W-1:0] == m_tdata_reg[11:0])
        else $error("chosen size differs from reported measure size");

    a_trial_no_revive: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_op_reg == sap_pkg::OP_MEASURE && !in_first_reg
        |=> (trial_fits_reg & ~$past(trial_fits_reg)) == '0)
        else $error("failed trial revived without a first beat");

endmodule
